// File: hw/rtl/sd_card_command_sequencer_macros.svh
// Assertion macros of the SD command sequencer top level.
`ifndef SD_CARD_COMMAND_SEQUENCER_MACROS_SVH
`define SD_CARD_COMMAND_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SDCS_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SDCS_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/sdcs_pkg.sv
// Shared types, codes and constants of the SD command sequencer.
`default_nettype none

package sdcs_pkg;

	// Geometry
	localparam int BLOCK_BYTES    = 512;
	localparam int BLOCK_SHIFT    = $clog2(BLOCK_BYTES);
	localparam int OBUF_DEPTH_DEF = 4;

	// Register reset
	localparam logic [16:0] POLL_LIMIT_RST = 17'd100000;

	// Event modes on s_tuser
	localparam logic [2:0] MODE_INIT  = 3'd0;
	localparam logic [2:0] MODE_READ  = 3'd1;
	localparam logic [2:0] MODE_WRITE = 3'd2;
	localparam logic [2:0] MODE_CMD   = 3'd3;
	localparam logic [2:0] MODE_DATA  = 3'd4;

	// Command numbers
	localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
	localparam logic [5:0] CMD_ALL_CID    = 6'd2;
	localparam logic [5:0] CMD_SEND_RCA   = 6'd3;
	localparam logic [5:0] ACMD_BUS_WIDTH = 6'd6;
	localparam logic [5:0] CMD_SELECT     = 6'd7;
	localparam logic [5:0] CMD_IF_COND    = 6'd8;
	localparam logic [5:0] CMD_SEND_CSD   = 6'd9;
	localparam logic [5:0] CMD_STOP       = 6'd12;
	localparam logic [5:0] CMD_STATUS     = 6'd13;
	localparam logic [5:0] CMD_BLOCKLEN   = 6'd16;
	localparam logic [5:0] CMD_RD_SINGLE  = 6'd17;
	localparam logic [5:0] CMD_RD_MULTI   = 6'd18;
	localparam logic [5:0] CMD_WR_SINGLE  = 6'd24;
	localparam logic [5:0] CMD_WR_MULTI   = 6'd25;
	localparam logic [5:0] ACMD_OP_COND   = 6'd41;
	localparam logic [5:0] CMD_APP        = 6'd55;

	// Command arguments and response fields
	localparam logic [31:0] IF_COND_ARG    = 32'h0000_01AA;
	localparam logic [31:0] OP_COND_ARG    = 32'h4030_0000;
	localparam logic [31:0] BUS_WIDTH_4BIT = 32'd2;
	localparam logic [3:0]  STATE_TRAN     = 4'd4;
	localparam logic [1:0]  CSD_VER2       = 2'd1;

	// Action codes of a result word
	typedef enum logic [2:0] {
		ACT_CMD   = 3'd0,
		ACT_READ  = 3'd1,
		ACT_WRITE = 3'd2,
		ACT_BUS   = 3'd3,
		ACT_DONE  = 3'd4
	} action_t;

	// Expected response kinds
	typedef enum logic [2:0] {
		RSP_NONE = 3'd0,
		RSP_R1   = 3'd1,
		RSP_R2   = 3'd2,
		RSP_R3   = 3'd3,
		RSP_R6   = 3'd4,
		RSP_R7   = 3'd5
	} resp_kind_t;

	// One result word
	typedef struct packed {
		action_t     action;
		logic [5:0]  cmd_index;
		logic [31:0] cmd_argument;
		resp_kind_t  resp_kind;
		logic [31:0] byte_length;
		logic        bus_four_bit;
		logic        clock_fast;
		logic        status;
		logic [31:0] capacity_blocks;
		logic        last;
	} res_t;

	// Results of one step handed to the output buffer
	typedef struct packed {
		logic [1:0] cnt;
		res_t       w0;
		res_t       w1;
	} obuf_wr_t;

endpackage

`default_nettype wire

// File: hw/rtl/sdcs_csd_dec.sv
// CSD decoder: card capacity in 512-byte blocks from CSD version 1 or 2.
`default_nettype none

module sdcs_csd_dec (
	input  wire logic [31:0] w1,
	input  wire logic [31:0] w2,
	input  wire logic [31:0] w3,
	output logic      [31:0] cap
);
	import sdcs_pkg::*;

	logic [21:0] c_v2;
	logic [11:0] c_v1;
	logic [12:0] c_v1_p1;
	logic [4:0]  shamt;
	logic [36:0] bytes_v1;

	// Version 2: (c_size + 1) * 1024, saturating
	assign c_v2 = {w2[5:0], w1[31:16]};

	// Version 1: (c_size + 1) << (mult + 2) << read block length, in blocks
	assign c_v1     = {w2[9:0], w1[31:30]};
	assign c_v1_p1  = {1'b0, c_v1} + 13'd1;
	assign shamt    = 5'd2 + {2'b00, w1[17:15]} + {1'b0, w2[19:16]};
	assign bytes_v1 = {24'd0, c_v1_p1} << shamt;

	always_comb begin
		if (w3[31:30] == CSD_VER2) begin
			if (&c_v2)
				cap = 32'hFFFF_FFFF;
			else
				cap = {c_v2 + 22'd1, 10'd0};
		end else begin
			cap = 32'(bytes_v1 >> BLOCK_SHIFT);
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sdcs_ctrl.sv
// Sequencer core: input register, card state and the per-word step logic.
`default_nettype none

module sdcs_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [199:0]             s_tdata,   // block_address, block_count, failed,
	                                                 // resp_word0..3, zero pad
	input  wire logic [2:0]               s_tuser,   // mode
	input  wire logic [16:0]              poll_limit,
	input  wire logic                     room_two,
	output sdcs_pkg::obuf_wr_t            wr
);
	import sdcs_pkg::*;

	typedef enum logic [18:0] {
		PH_IDLE    = 19'h00001,
		PH_CMD0    = 19'h00002,
		PH_CMD8    = 19'h00004,
		PH_CMD55A  = 19'h00008,
		PH_ACMD41  = 19'h00010,
		PH_CMD2    = 19'h00020,
		PH_CMD3    = 19'h00040,
		PH_CMD7    = 19'h00080,
		PH_CMD16   = 19'h00100,
		PH_CMD55B  = 19'h00200,
		PH_ACMD6   = 19'h00400,
		PH_CMD9    = 19'h00800,
		PH_RD_CMD  = 19'h01000,
		PH_RD_DATA = 19'h02000,
		PH_RD_STOP = 19'h04000,
		PH_WR_CMD  = 19'h08000,
		PH_WR_DATA = 19'h10000,
		PH_WR_STOP = 19'h20000,
		PH_POLL    = 19'h40000
	} phase_t;

	// Input register
	logic          in_valid_s1;
	logic [2:0]    mode_s1;
	logic [31:0]   lba_s1;
	logic [31:0]   count_s1;
	logic          fail_s1;
	logic [31:0]   r0_s1;
	logic [31:0]   r1_s1;
	logic [31:0]   r2_s1;
	logic [31:0]   r3_s1;

	// Card state
	phase_t        phase_q,    phase_n;
	logic [15:0]   rca_q,      rca_n;
	logic          hc_q,       hc_n;
	logic [31:0]   cap_q,      cap_n;
	logic [16:0]   poll_q,     poll_n;
	logic [31:0]   xfer_q,     xfer_n;
	logic          multi_q,    multi_n;

	logic          go;
	logic [31:0]   csd_cap;
	logic [31:0]   rca_arg;
	logic [31:0]   addr;
	logic          multi_req;
	logic [16:0]   poll_inc;
	logic          tran_ok;
	logic [1:0]    n;
	res_t          ra, rb;

	function automatic res_t mk_cmd(input logic [5:0] idx, input logic [31:0] arg,
			input resp_kind_t k);
		res_t r;
		r              = '0;
		r.action       = ACT_CMD;
		r.cmd_index    = idx;
		r.cmd_argument = arg;
		r.resp_kind    = k;
		return r;
	endfunction

	function automatic res_t mk_bus(input logic four, input logic fast);
		res_t r;
		r              = '0;
		r.action       = ACT_BUS;
		r.bus_four_bit = four;
		r.clock_fast   = fast;
		return r;
	endfunction

	function automatic res_t mk_data(input action_t act, input logic [31:0] len);
		res_t r;
		r             = '0;
		r.action      = act;
		r.byte_length = len;
		return r;
	endfunction

	function automatic res_t mk_done(input logic f);
		res_t r;
		r        = '0;
		r.action = ACT_DONE;
		r.status = f;
		return r;
	endfunction

	sdcs_csd_dec u_csd (
		.w1  (r1_s1),
		.w2  (r2_s1),
		.w3  (r3_s1),
		.cap (csd_cap)
	);

	// Step when a word waits and the output buffer can take two results
	assign go       = in_valid_s1 && room_two;
	assign s_tready = !in_valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_valid_s1 <= 1'b0;
		else if (s_tready)
			in_valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1  <= s_tuser;
			lba_s1   <= s_tdata[31:0];
			count_s1 <= s_tdata[63:32];
			fail_s1  <= s_tdata[64];
			r0_s1    <= s_tdata[96:65];
			r1_s1    <= s_tdata[128:97];
			r2_s1    <= s_tdata[160:129];
			r3_s1    <= s_tdata[192:161];
		end
	end

	// Operands of the step
	assign rca_arg   = {rca_q, 16'd0};
	assign addr      = hc_q ? lba_s1 : (lba_s1 << BLOCK_SHIFT);
	assign multi_req = count_s1 > 32'd1;
	assign poll_inc  = poll_q + 17'd1;
	assign tran_ok   = r0_s1[8] && (r0_s1[12:9] == STATE_TRAN);

	// Step logic: next state and up to two results
	always_comb begin
		phase_n = phase_q;
		rca_n   = rca_q;
		hc_n    = hc_q;
		cap_n   = cap_q;
		poll_n  = poll_q;
		xfer_n  = xfer_q;
		multi_n = multi_q;
		n       = 2'd0;
		ra      = '0;
		rb      = '0;
		case (mode_s1)
			MODE_INIT: begin
				hc_n    = 1'b0;
				ra      = mk_bus(1'b0, 1'b0);
				rb      = mk_cmd(CMD_GO_IDLE, 32'd0, RSP_NONE);
				n       = 2'd2;
				phase_n = PH_CMD0;
			end
			MODE_READ, MODE_WRITE: begin
				n = 2'd1;
				if (count_s1 == 32'd0) begin
					ra      = mk_done(1'b0);
					phase_n = PH_IDLE;
				end else begin
					multi_n = multi_req;
					xfer_n  = count_s1 << BLOCK_SHIFT;
					if (mode_s1 == MODE_READ) begin
						ra      = mk_cmd(multi_req ? CMD_RD_MULTI : CMD_RD_SINGLE, addr,
							RSP_R1);
						phase_n = PH_RD_CMD;
					end else begin
						ra      = mk_cmd(multi_req ? CMD_WR_MULTI : CMD_WR_SINGLE, addr,
							RSP_R1);
						phase_n = PH_WR_CMD;
					end
				end
			end
			MODE_CMD: begin
				n = 2'd1;
				case (phase_q)
					PH_CMD0: begin
						ra      = mk_cmd(CMD_IF_COND, IF_COND_ARG, RSP_R7);
						phase_n = PH_CMD8;
					end
					PH_CMD8: begin
						if (r0_s1[11:0] != IF_COND_ARG[11:0]) begin
							ra      = mk_done(1'b1);
							phase_n = PH_IDLE;
						end else begin
							ra      = mk_cmd(CMD_APP, 32'd0, RSP_R1);
							phase_n = PH_CMD55A;
						end
					end
					PH_CMD55A: begin
						ra      = mk_cmd(ACMD_OP_COND, OP_COND_ARG, RSP_R3);
						phase_n = PH_ACMD41;
					end
					PH_ACMD41: begin
						if (r0_s1[31]) begin
							hc_n    = r0_s1[30];
							ra      = mk_cmd(CMD_ALL_CID, 32'd0, RSP_R2);
							phase_n = PH_CMD2;
						end else begin
							ra      = mk_cmd(CMD_APP, 32'd0, RSP_R1);
							phase_n = PH_CMD55A;
						end
					end
					PH_CMD2: begin
						ra      = mk_cmd(CMD_SEND_RCA, 32'd0, RSP_R6);
						phase_n = PH_CMD3;
					end
					PH_CMD3: begin
						rca_n   = r0_s1[31:16];
						ra      = mk_cmd(CMD_SELECT, {r0_s1[31:16], 16'd0}, RSP_R1);
						phase_n = PH_CMD7;
					end
					PH_CMD7: begin
						ra      = mk_cmd(CMD_BLOCKLEN, 32'(BLOCK_BYTES), RSP_R1);
						phase_n = PH_CMD16;
					end
					PH_CMD16: begin
						ra      = mk_cmd(CMD_APP, rca_arg, RSP_R1);
						phase_n = PH_CMD55B;
					end
					PH_CMD55B: begin
						ra      = mk_cmd(ACMD_BUS_WIDTH, BUS_WIDTH_4BIT, RSP_R1);
						phase_n = PH_ACMD6;
					end
					PH_ACMD6: begin
						ra      = mk_bus(1'b1, 1'b1);
						rb      = mk_cmd(CMD_SEND_CSD, rca_arg, RSP_R2);
						n       = 2'd2;
						phase_n = PH_CMD9;
					end
					PH_CMD9: begin
						if (!fail_s1)
							cap_n = csd_cap;
						ra      = mk_done(1'b0);
						phase_n = PH_IDLE;
					end
					PH_RD_CMD: begin
						ra      = mk_data(ACT_READ, xfer_q);
						phase_n = PH_RD_DATA;
					end
					PH_WR_CMD: begin
						ra      = mk_data(ACT_WRITE, xfer_q);
						phase_n = PH_WR_DATA;
					end
					PH_RD_STOP: begin
						ra      = mk_done(fail_s1);
						phase_n = PH_IDLE;
					end
					PH_WR_STOP: begin
						poll_n  = 17'd0;
						ra      = mk_cmd(CMD_STATUS, rca_arg, RSP_R1);
						phase_n = PH_POLL;
					end
					PH_POLL: begin
						poll_n = poll_inc;
						if (tran_ok) begin
							ra      = mk_done(1'b0);
							phase_n = PH_IDLE;
						end else if (poll_inc >= poll_limit) begin
							ra      = mk_done(1'b1);
							phase_n = PH_IDLE;
						end else begin
							ra = mk_cmd(CMD_STATUS, rca_arg, RSP_R1);
						end
					end
					default: n = 2'd0;
				endcase
				// Failure overrides every command wait except CMD16, CMD9 and the read stop
				if (fail_s1 && (n != 2'd0) && phase_q != PH_CMD16 && phase_q != PH_CMD9
						&& phase_q != PH_RD_STOP) begin
					phase_n = PH_IDLE;
					rca_n   = rca_q;
					hc_n    = hc_q;
					poll_n  = poll_q;
					ra      = mk_done(1'b1);
					n       = 2'd1;
				end
			end
			MODE_DATA: begin
				if (phase_q == PH_RD_DATA || phase_q == PH_WR_DATA) begin
					n = 2'd1;
					if (fail_s1 || !multi_q) begin
						ra      = mk_done(fail_s1);
						phase_n = PH_IDLE;
					end else begin
						ra      = mk_cmd(CMD_STOP, 32'd0, RSP_R1);
						phase_n = (phase_q == PH_RD_DATA) ? PH_RD_STOP : PH_WR_STOP;
					end
				end
			end
			default: n = 2'd0;
		endcase
		// Capacity after this word, last flag on the final result
		ra.capacity_blocks = cap_n;
		rb.capacity_blocks = cap_n;
		ra.last            = (n == 2'd1);
		rb.last            = (n == 2'd2);
	end

	always_comb begin
		wr.cnt = go ? n : 2'd0;
		wr.w0  = ra;
		wr.w1  = rb;
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			rca_q   <= '0;
			hc_q    <= 1'b0;
			cap_q   <= '0;
			poll_q  <= '0;
			xfer_q  <= '0;
			multi_q <= 1'b0;
		end else if (go) begin
			phase_q <= phase_n;
			rca_q   <= rca_n;
			hc_q    <= hc_n;
			cap_q   <= cap_n;
			poll_q  <= poll_n;
			xfer_q  <= xfer_n;
			multi_q <= multi_n;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sdcs_obuf.sv
// Result buffer: takes up to two result words a cycle, sends one a cycle while out_ready is high.
`default_nettype none

module sdcs_obuf #(
	parameter int DEPTH = sdcs_pkg::OBUF_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire sdcs_pkg::obuf_wr_t         wr,
	output logic                            room_two,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output sdcs_pkg::res_t                  out_word,
	output logic [$clog2(DEPTH+1)-1:0]      level
);
	import sdcs_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	res_t          mem_q [DEPTH];
	logic [IW-1:0] wr_q, rd_q;
	logic [IW-1:0] wr_p1;
	logic [LW-1:0] level_q;
	logic          pop;

	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] p);
		return (p == IW'(DEPTH - 1)) ? '0 : p + IW'(1);
	endfunction

	assign wr_p1     = nxt(wr_q);
	assign out_valid = (level_q != '0);
	assign out_word  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign room_two  = (level_q <= LW'(DEPTH - 2));
	assign level     = level_q;

	// Storage
	always_ff @(posedge clk) begin
		if (wr.cnt != 2'd0)
			mem_q[wr_q] <= wr.w0;
		if (wr.cnt == 2'd2)
			mem_q[wr_p1] <= wr.w1;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (wr.cnt == 2'd1)
				wr_q <= wr_p1;
			else if (wr.cnt == 2'd2)
				wr_q <= nxt(wr_p1);
			if (pop)
				rd_q <= nxt(rd_q);
			level_q <= level_q + LW'(wr.cnt) - LW'(pop);
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sd_card_command_sequencer.sv
// Top level of the SD card host command sequencer.
//
//  channel  direction  handshake            payload
//  s_*      in         s_tvalid / s_tready  tuser: mode; tdata: request or event word
//  m_*      out        m_tvalid / m_tready  tuser: action; tdata: result; tlast: last
//  cfg_*    in         cfg_valid / cfg_ready cfg_data: poll_limit (always ready)
//
// A word waits in the input register; the step logic then writes one or two
// results into a small result buffer, which sends one per cycle while m_tready
// is high. Words with one result sustain one per cycle while m_tready is high;
// words with two results are held back by the single output port of the buffer.
// The input register holds while the buffer has less than two free entries.
// arst_n clears phase, card state, buffer pointers and poll_limit (100000).
`default_nettype none

module sd_card_command_sequencer #(
	parameter int OBUF_DEPTH = sdcs_pkg::OBUF_DEPTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [199:0] s_tdata,   // block_address, block_count, failed,
	                                     // resp_word0, resp_word1, resp_word2, resp_word3
	input  wire logic [2:0]   s_tuser,   // mode
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [111:0]      m_tdata,   // cmd_index, cmd_argument, resp_kind, byte_length,
	                                     // bus_four_bit, clock_fast, status, capacity_blocks
	output logic [2:0]        m_tuser,   // action
	output logic              m_tlast,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [16:0]  cfg_data
);
	import sdcs_pkg::*;

`include "sd_card_command_sequencer_macros.svh"

	localparam int OB_LW = $clog2(OBUF_DEPTH + 1);

	logic [16:0]      poll_limit_q;
	logic             room_two;
	obuf_wr_t         wr;
	res_t             head;
	logic [OB_LW-1:0] ob_level;

	// Poll limit register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			poll_limit_q <= POLL_LIMIT_RST;
		else if (cfg_valid && cfg_ready)
			poll_limit_q <= cfg_data;
	end

	sdcs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.poll_limit (poll_limit_q),
		.room_two   (room_two),
		.wr         (wr)
	);

	sdcs_obuf #(
		.DEPTH (OBUF_DEPTH)
	) u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.room_two  (room_two),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (head),
		.level     (ob_level)
	);

	// Output word packing
	assign m_tuser = head.action;
	assign m_tlast = head.last;
	assign m_tdata = {4'd0, head.capacity_blocks, head.status, head.clock_fast,
		head.bus_four_bit, head.byte_length, head.resp_kind, head.cmd_argument,
		head.cmd_index};

	// Checks
	`SDCS_CHECK(a_obuf_bound, 1'b1, ob_level <= OB_LW'(OBUF_DEPTH), "result buffer overfilled")
	`SDCS_CHECK(a_valid_level, 1'b1, m_tvalid == (ob_level != '0), "m_tvalid disagrees with fill")
	`SDCS_CHECK(a_done_last, m_tvalid && m_tuser == ACT_DONE, m_tlast, "finish word without last")
	`SDCS_CHECK_NEXT(a_cfg_write, cfg_valid && cfg_ready, poll_limit_q == $past(cfg_data), "poll_limit not written")

endmodule

`default_nettype wire
